>>> design/moving_min_rank_average_filter_top_macros.svh
// Assertion helpers used by the filter's top module
`ifndef MOVING_MIN_RANK_AVERAGE_FILTER_TOP_MACROS_SVH
`define MOVING_MIN_RANK_AVERAGE_FILTER_TOP_MACROS_SVH
// Check a property on every rising clock edge outside reset
`define MRAF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check that a condition in one cycle is followed by another in the next
`define MRAF_ASSERT_NEXT(lbl, cond, nxt, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);
`endif

>>> design/mraf_pkg.sv
// ----------------------------------------------------------------------------
// mraf_pkg
// Shared constants and types of the rank-order trimmed mean filter.
// ----------------------------------------------------------------------------
`default_nettype none
package mraf_pkg;
   localparam int MAX_WINDOW = 64;
   localparam int IDX_W      = $clog2(MAX_WINDOW);
   localparam int LEN_W      = IDX_W + 1;
   localparam int DATA_W     = 64;
   localparam int SUM_W      = DATA_W + IDX_W + 1;
   localparam int DCNT_W     = $clog2(SUM_W + 1);

   typedef enum logic [2:0] {
      OP_HOLD    = 3'd0,
      OP_CLEAR   = 3'd1,
      OP_MARK    = 3'd2,
      OP_COMPACT = 3'd3,
      OP_INSERT  = 3'd4,
      OP_ROTATE  = 3'd5
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [DATA_W-1:0]   sample;
      logic [IDX_W-1:0]    pos;
   } ctrl_type;

   typedef struct packed {
      logic                valid;
      logic                hole;
      logic [IDX_W-1:0]    tag;
      logic [DATA_W-1:0]   value;
   } cell_type;
endpackage
`default_nettype wire

>>> design/mraf_cell.sv
// ----------------------------------------------------------------------------
// mraf_cell
// One rank slot of the sorted chain: holds a sample and its ring position.
// ----------------------------------------------------------------------------
`default_nettype none
module mraf_cell
   import mraf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire ctrl_type ctrl,
   input  wire cell_type up_in,     // neighbour one rank higher
   input  wire cell_type down_in,   // neighbour one rank lower
   input  wire logic     down_keep, // lower neighbour stays put on insertion
   output cell_type      data_out,
   output logic          keep_out
);
   cell_type data_ff, data_in;

   assign keep_out = data_ff.valid && ($signed(data_ff.value) <= $signed(ctrl.sample));
   assign data_out = data_ff;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         OP_CLEAR: begin
            data_in.valid = 1'b0;
            data_in.hole  = 1'b0;
         end
         OP_MARK: begin
            data_in.hole = data_ff.valid && (data_ff.tag == ctrl.pos);
         end
         OP_COMPACT: begin
            // pull the upper neighbour into the hole; the hole climbs
            if (data_ff.hole) begin
               data_in      = up_in;
               data_in.hole = 1'b0;
            end else if (down_in.hole) begin
               data_in.hole = 1'b1;
            end
         end
         OP_INSERT: begin
            if (!keep_out) begin
               if (down_keep) begin
                  data_in.valid = 1'b1;
                  data_in.hole  = 1'b0;
                  data_in.tag   = ctrl.pos;
                  data_in.value = ctrl.sample;
               end else begin
                  data_in = down_in;
               end
            end
         end
         OP_ROTATE: data_in = up_in;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
         data_ff.hole  <= 1'b0;
         data_ff.tag   <= data_in.tag;
         data_ff.value <= data_in.value;
      end else begin
         data_ff <= data_in;
      end
   end
endmodule
`default_nettype wire

>>> design/mraf_div.sv
// ----------------------------------------------------------------------------
// mraf_div
// Restoring divider, one quotient bit a cycle, magnitude by rank count.
// ----------------------------------------------------------------------------
`default_nettype none
module mraf_div
   import mraf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] dividend,
   input  wire logic [LEN_W-1:0] divisor,
   output logic                  done,
   output logic [SUM_W-1:0]      quotient
);
   logic [SUM_W-1:0]  dvd_ff, dvd_in;
   logic [LEN_W-1:0]  rem_ff, rem_in, dsr_ff;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [LEN_W:0]    trial;

   assign trial    = {rem_ff, dvd_ff[SUM_W-1]};
   assign done     = done_ff;
   assign quotient = dvd_ff;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = LEN_W'(trial - {1'b0, dsr_ff});
            dvd_in = {dvd_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[LEN_W-1:0];
            dvd_in = {dvd_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) dsr_ff <= divisor;
   end
endmodule
`default_nettype wire

>>> design/moving_min_rank_average_filter_top.sv
// ----------------------------------------------------------------------------
// moving_min_rank_average_filter_top
// Sliding window trimmed mean over signed 64-bit time samples.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// req_      in         req_tvalid/tready    tdata = sample_value[63:0]
// rsp_      out        rsp_tvalid/tready    tdata = filtered_value[63:0]
// csr_      in         csr_we               csr_index, csr_wdata
//
// A request runs mark, hole climb, insert, rank sweep, divide and result
// in that order when the window is full, and skips mark and hole climb while
// it fills; a request with no rank selected skips the divide. The rank sweep
// and the bit-serial divider take the bulk of the time.
// Reset is synchronous and active high and empties the window; so does a write
// to the window length, first or last rank register. A new request is taken
// while a result waits; a stalled result only holds the block at its final step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "moving_min_rank_average_filter_top_macros.svh"
module moving_min_rank_average_filter_top
   import mraf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,   // [63:0] sample_value
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // [63:0] filtered_value
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [LEN_W-1:0]  csr_wdata
);
   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_MARK    = 7'b0000010,
      ST_COMPACT = 7'b0000100,
      ST_INSERT  = 7'b0001000,
      ST_SUM     = 7'b0010000,
      ST_DIV     = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   localparam logic [1:0] REG_WLEN  = 2'd0;
   localparam logic [1:0] REG_FIRST = 2'd1;
   localparam logic [1:0] REG_LAST  = 2'd2;

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   wlen_ff, len_eff, fill_ff, fill_in, cnt_ff, cnt_in;
   logic [IDX_W-1:0]   first_ff, last_ff, wpos_ff, wpos_in, step_ff, step_in;
   logic [DATA_W-1:0]  sample_ff, out_ff, out_in, res_ff, res_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic               neg_ff, rsp_valid_ff, rsp_valid_in;
   logic               cfg_hit, req_acc, div_start, div_done;
   logic [SUM_W-1:0]   div_q, mag;
   ctrl_type           ctrl;
   cell_type           cells [MAX_WINDOW];
   logic               keeps [MAX_WINDOW];

   assign cfg_hit = csr_we && (csr_index == REG_WLEN || csr_index == REG_FIRST ||
                               csr_index == REG_LAST);
   assign len_eff = (wlen_ff == '0) ? LEN_W'(1) :
                    (wlen_ff > LEN_W'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) : wlen_ff;
   assign req_tready = (state_ff == ST_IDLE) && !csr_we;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_ff;
   // magnitude of the finished sum, taken as the divider starts
   assign mag        = acc_in[SUM_W-1] ? SUM_W'(-acc_in) : SUM_W'(acc_in);

   // broadcast command to the chain
   always_comb begin
      ctrl.sample = sample_ff;
      ctrl.pos    = wpos_ff;
      ctrl.op     = OP_HOLD;
      if (cfg_hit) ctrl.op = OP_CLEAR;
      else begin
         case (state_ff)
            ST_MARK:    ctrl.op = OP_MARK;
            ST_COMPACT: ctrl.op = OP_COMPACT;
            ST_INSERT:  ctrl.op = OP_INSERT;
            ST_SUM:     ctrl.op = OP_ROTATE;
            default:    ctrl.op = OP_HOLD;
         endcase
      end
   end

   // chain of rank cells; in a sweep the top closes the ring onto rank zero
   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      cell_type up_w, down_w;
      logic     dkeep_w;
      if (i == MAX_WINDOW - 1) begin : g_top
         assign up_w = (ctrl.op == OP_ROTATE) ? cells[0] : '0;
      end else begin : g_mid
         assign up_w = cells[i+1];
      end
      if (i == 0) begin : g_bot
         assign down_w  = '0;
         assign dkeep_w = 1'b1;
      end else begin : g_up
         assign down_w  = cells[i-1];
         assign dkeep_w = keeps[i-1];
      end
      mraf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .up_in    (up_w),
         .down_in  (down_w),
         .down_keep(dkeep_w),
         .data_out (cells[i]),
         .keep_out (keeps[i])
      );
   end

   assign div_start = (state_ff == ST_SUM) && (step_ff == IDX_W'(MAX_WINDOW - 1)) &&
                      (cnt_in != '0);

   mraf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(mag),
      .divisor (cnt_in),
      .done    (div_done),
      .quotient(div_q)
   );

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      wpos_in      = wpos_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      out_in       = out_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) state_in = (fill_ff == len_eff) ? ST_MARK : ST_INSERT;
         end
         ST_MARK: begin
            step_in  = '0;
            state_in = ST_COMPACT;
         end
         ST_COMPACT: begin
            // climb the hole out past the top cell
            step_in = step_ff + 1'b1;
            if (step_ff == IDX_W'(MAX_WINDOW - 1)) state_in = ST_INSERT;
         end
         ST_INSERT: begin
            if (fill_ff != len_eff) fill_in = fill_ff + 1'b1;
            wpos_in  = ({1'b0, wpos_ff} + 1'b1 == len_eff) ? '0 : wpos_ff + 1'b1;
            step_in  = '0;
            acc_in   = '0;
            cnt_in   = '0;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // rank step_ff sits in cell zero this cycle
            if (cells[0].valid && step_ff >= first_ff && step_ff <= last_ff) begin
               acc_in = acc_ff + SUM_W'($signed(cells[0].value));
               cnt_in = cnt_ff + 1'b1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == IDX_W'(MAX_WINDOW - 1)) begin
               if (cnt_in == '0) begin
                  res_in   = sample_ff;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = neg_ff ? DATA_W'(-div_q) : div_q[DATA_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cfg_hit) begin
         fill_in = '0;
         wpos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         wpos_ff      <= '0;
         wlen_ff      <= LEN_W'(10);
         first_ff     <= '0;
         last_ff      <= IDX_W'(2);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         wpos_ff      <= wpos_in;
         if (csr_we) begin
            case (csr_index)
               REG_WLEN:  wlen_ff  <= csr_wdata;
               REG_FIRST: first_ff <= csr_wdata[IDX_W-1:0];
               REG_LAST:  last_ff  <= csr_wdata[IDX_W-1:0];
               default:   ;
            endcase
         end
      end
      if (req_acc) sample_ff <= req_tdata;
      if (div_start) neg_ff <= acc_in[SUM_W-1];
      step_ff <= step_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   `MRAF_ASSERT(a_fill_bound, (fill_ff <= LEN_W'(MAX_WINDOW)), "fill count above window")
   `MRAF_ASSERT_NEXT(a_one_req, req_acc, !req_tready, "second request taken while busy")
   `MRAF_ASSERT_NEXT(a_sweep_end, (state_ff == ST_SUM && step_ff == IDX_W'(MAX_WINDOW - 1)),
      (state_ff == ST_DIV || state_ff == ST_DONE), "rank sweep did not finish")
endmodule
`default_nettype wire
